>>> rtl/slice_page_allocator_unit_assert.svh
// Assertion macros used by the slice page allocator controller.
`ifndef SLICE_PAGE_ALLOCATOR_UNIT_ASSERT_SVH
`define SLICE_PAGE_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPA_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/spa_pkg.sv
// Shared types and codes of the slice page allocator.
`default_nettype none
package spa_pkg;

    localparam int FILL_W = 8;
    localparam int INFO_W = 2 + FILL_W + 1;

    // List tags kept per slice
    localparam logic [1:0] TAG_UNUSED = 2'd0;
    localparam logic [1:0] TAG_ALLOC  = 2'd1;
    localparam logic [1:0] TAG_L2     = 2'd2;
    localparam logic [1:0] TAG_PAGE   = 2'd3;

    // Command kinds
    localparam logic [2:0] KIND_INIT        = 3'd0;
    localparam logic [2:0] KIND_ALLOC_SLICE = 3'd1;
    localparam logic [2:0] KIND_ALLOC_L2    = 3'd2;
    localparam logic [2:0] KIND_ALLOC_PAGE  = 3'd3;
    localparam logic [2:0] KIND_FREE_SLICE  = 3'd4;
    localparam logic [2:0] KIND_FREE_L2     = 3'd5;
    localparam logic [2:0] KIND_FREE_PAGE   = 3'd6;

    // Result status codes
    localparam logic [1:0] RES_OK       = 2'd0;
    localparam logic [1:0] RES_OOM      = 2'd1;
    localparam logic [1:0] RES_RESERVED = 2'd2;
    localparam logic [1:0] RES_RANGE    = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_REGION_BASE    = 2'd0;
    localparam logic [1:0] REG_SLICES_IN_USE  = 2'd1;
    localparam logic [1:0] REG_RESERVED_BASE  = 2'd2;
    localparam logic [1:0] REG_RESERVED_LIMIT = 2'd3;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECIDE = 8'b0000_0010,
        ST_READ   = 8'b0000_0100,
        ST_UPD    = 8'b0000_1000,
        ST_PUSH1  = 8'b0001_0000,
        ST_PUSH2  = 8'b0010_0000,
        ST_WALK   = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } spa_state_t;

    typedef struct packed {
        logic accept;
        logic decide;
        logic read;
        logic upd;
        logic push1;
        logic push2;
        logic walk;
        logic fin;
    } spa_cmd_t;

    typedef struct packed {
        logic is_init;
        logic dec_stop;
        logic upd_stop;
        logic do_push;
        logic walk_last;
    } spa_stat_t;

endpackage
`default_nettype wire

>>> rtl/spa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/spa_ctrl.sv
// Sequencing state machine of the slice page allocator.
`default_nettype none
`include "slice_page_allocator_unit_assert.svh"
module spa_ctrl
    import spa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output logic           done,
    output spa_cmd_t       cmd,
    input  wire spa_stat_t stat
);

    spa_state_t state_reg, state_next;
    logic       done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.is_init)
                begin
                    state_next = ST_WALK;
                end
                else if (stat.dec_stop)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (stat.upd_stop)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    state_next = ST_PUSH1;
                end
            end
            ST_PUSH1:
            begin
                if (stat.do_push)
                begin
                    state_next = ST_PUSH2;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_PUSH2:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            ST_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign cmd.accept = start && (state_reg == ST_IDLE);
    assign cmd.decide = (state_reg == ST_DECIDE);
    assign cmd.read   = (state_reg == ST_READ);
    assign cmd.upd    = (state_reg == ST_UPD);
    assign cmd.push1  = (state_reg == ST_PUSH1);
    assign cmd.push2  = (state_reg == ST_PUSH2);
    assign cmd.walk   = (state_reg == ST_WALK);
    assign cmd.fin    = (state_reg == ST_FIN);

    `SPA_ASSERT_IMPLY(a_done_idle, done_reg, state_reg == ST_IDLE, "strobe while busy")
    `SPA_ASSERT_NEXT(a_accept_decide, cmd.accept, state_reg == ST_DECIDE, "accept lost")
    `SPA_ASSERT_NEXT(a_done_single, done_reg, !done_reg, "result strobed twice")

endmodule
`default_nettype wire

>>> rtl/spa_datapath.sv
// Datapath of the slice page allocator: list heads, slice memories, result.
`default_nettype none
module spa_datapath
    import spa_pkg::*;
#(
    parameter int SLICE_COUNT     = 1024,
    parameter int SLICE_SHIFT     = 14,
    parameter int L2_PER_SLICE    = 8,
    parameter int PAGES_PER_SLICE = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire spa_cmd_t    cmd,
    output spa_stat_t        stat,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] address,
    input  wire logic [31:0] region_base,
    input  wire logic [10:0] slices_in_use,
    input  wire logic [31:0] reserved_base,
    input  wire logic [31:0] reserved_limit,
    output logic      [31:0] block_address,
    output logic      [1:0]  status
);

    localparam int IW = $clog2(SLICE_COUNT);
    localparam int W  = $clog2(SLICE_COUNT + 1);
    localparam logic [W-1:0]  NIL         = W'(SLICE_COUNT);
    localparam logic [IW-1:0] LAST_IDX    = IW'(SLICE_COUNT - 1);
    localparam logic [31:0]   COUNT_MAX   = 32'(SLICE_COUNT);
    localparam logic [31:0]   SLICE_BYTES = 32'(1 << SLICE_SHIFT);
    localparam logic [31:0]   L2_BYTES    = 32'((1 << SLICE_SHIFT) / L2_PER_SLICE);
    localparam logic [31:0]   PG_BYTES    = 32'((1 << SLICE_SHIFT) / PAGES_PER_SLICE);
    localparam logic [FILL_W-1:0] L2_FULL = FILL_W'((1 << L2_PER_SLICE) - 1);
    localparam logic [FILL_W-1:0] PG_FULL = FILL_W'((1 << PAGES_PER_SLICE) - 1);

    // Sub-block index of an in-slice offset: count the thresholds passed.
    function automatic logic [2:0] sub_index(input logic [31:0] off, input logic [31:0] bytes);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (off >= 32'(k) * bytes)
            begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt[2:0];
    endfunction

    // Lowest clear fill bit within the mask: {found, index}.
    function automatic logic [3:0] first_clear(input logic [FILL_W-1:0] f,
                                               input logic [FILL_W-1:0] full);
        logic [3:0] res;
        res = 4'd0;
        for (int k = FILL_W - 1; k >= 0; k--)
        begin
            if (full[k] && !f[k])
            begin
                res = {1'b1, 3'(k)};
            end
        end
        return res;
    endfunction

    logic [2:0]             kind_reg, kind_next;
    logic [31:0]            addr_reg, addr_next;
    logic [IW-1:0]          s_reg, s_next;
    logic                   fresh_reg, fresh_next;
    logic [SLICE_SHIFT-1:0] in_reg, in_next;
    logic [31:0]            blk_reg, blk_next;
    logic [2:0]             sub_reg, sub_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [1:0]             ptag_reg, ptag_next;
    logic                   push_reg, push_next;
    logic                   resv_reg, resv_next;
    logic [2:0]             bit_reg, bit_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [31:0]            acc_reg, acc_next;
    logic [31:0]            res_block_reg, res_block_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic [W-1:0]           uh_reg, uh_next, l2h_reg, l2h_next, pgh_reg, pgh_next;
    logic [31:0]            mbase_reg, mbase_next;
    logic [W-1:0]           mcount_reg, mcount_next;

    logic              info_we, next_we, prev_we;
    logic [IW-1:0]     info_waddr, next_waddr, prev_waddr;
    logic [INFO_W-1:0] info_wdata, info_rdata;
    logic [W-1:0]      next_wdata, prev_wdata, next_rdata, prev_rdata;

    logic [31:0]       off, off_sh, siu_ext, cnt32, s_ext;
    logic [1:0]        r_tag;
    logic [FILL_W-1:0] r_fill, base_fill, new_fill, full_mask;
    logic              r_resv, win_hit, managed;
    logic [3:0]        fc;
    logic [W-1:0]      h_sel;

    assign off     = addr_reg - mbase_reg;
    assign off_sh  = off >> SLICE_SHIFT;
    assign siu_ext = 32'(slices_in_use);
    assign cnt32   = (siu_ext < COUNT_MAX) ? siu_ext : COUNT_MAX;
    assign s_ext   = 32'(s_reg);
    assign r_tag   = info_rdata[INFO_W-1 -: 2];
    assign r_fill  = info_rdata[FILL_W:1];
    assign r_resv  = info_rdata[0];
    assign win_hit = (reserved_limit > reserved_base) && (acc_reg >= reserved_base)
                     && (acc_reg < reserved_limit);
    assign managed = (W'(idx_reg) < mcount_reg);

    always_comb
    begin
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        s_next          = s_reg;
        fresh_next      = fresh_reg;
        in_next         = in_reg;
        blk_next        = blk_reg;
        sub_next        = sub_reg;
        fill_next       = fill_reg;
        ptag_next       = ptag_reg;
        push_next       = push_reg;
        resv_next       = resv_reg;
        bit_next        = bit_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        res_block_next  = res_block_reg;
        res_status_next = res_status_reg;
        uh_next         = uh_reg;
        l2h_next        = l2h_reg;
        pgh_next        = pgh_reg;
        mbase_next      = mbase_reg;
        mcount_next     = mcount_reg;
        info_we         = 1'b0;
        info_waddr      = s_reg;
        info_wdata      = {TAG_ALLOC, fill_reg, resv_reg};
        next_we         = 1'b0;
        next_waddr      = s_reg;
        next_wdata      = NIL;
        prev_we         = 1'b0;
        prev_waddr      = s_reg;
        prev_wdata      = NIL;
        stat            = '0;
        base_fill       = '0;
        new_fill        = '0;
        full_mask       = '0;
        fc              = '0;
        h_sel           = NIL;

        if (cmd.accept)
        begin
            kind_next = kind;
            addr_next = address;
        end

        if (cmd.decide)
        begin
            res_block_next  = '0;
            res_status_next = RES_OK;
            case (kind_reg)
                KIND_INIT:
                begin
                    stat.is_init = 1'b1;
                    uh_next      = NIL;
                    l2h_next     = NIL;
                    pgh_next     = NIL;
                    mbase_next   = region_base;
                    mcount_next  = cnt32[W-1:0];
                    idx_next     = '0;
                    acc_next     = region_base;
                end
                KIND_ALLOC_SLICE:
                begin
                    s_next     = uh_reg[IW-1:0];
                    fresh_next = 1'b1;
                    if (uh_reg == NIL)
                    begin
                        stat.dec_stop   = 1'b1;
                        res_status_next = RES_OOM;
                    end
                end
                KIND_ALLOC_L2, KIND_ALLOC_PAGE:
                begin
                    h_sel = (kind_reg == KIND_ALLOC_L2) ? l2h_reg : pgh_reg;
                    if (h_sel != NIL)
                    begin
                        s_next     = h_sel[IW-1:0];
                        fresh_next = 1'b0;
                    end
                    else
                    begin
                        s_next     = uh_reg[IW-1:0];
                        fresh_next = 1'b1;
                        if (uh_reg == NIL)
                        begin
                            stat.dec_stop   = 1'b1;
                            res_status_next = RES_OOM;
                        end
                    end
                end
                KIND_FREE_SLICE, KIND_FREE_L2, KIND_FREE_PAGE:
                begin
                    s_next  = off_sh[IW-1:0];
                    in_next = off[SLICE_SHIFT-1:0];
                    if (off_sh >= 32'(mcount_reg))
                    begin
                        stat.dec_stop   = 1'b1;
                        res_status_next = RES_RANGE;
                    end
                end
                default:
                begin
                    stat.dec_stop = 1'b1;
                end
            endcase
        end

        if (cmd.read)
        begin
            blk_next = mbase_reg + (s_ext << SLICE_SHIFT);
            sub_next = (kind_reg == KIND_FREE_L2) ? sub_index(32'(in_reg), L2_BYTES)
                                                  : sub_index(32'(in_reg), PG_BYTES);
        end

        if (cmd.upd)
        begin
            resv_next = r_resv;
            push_next = 1'b0;
            ptag_next = TAG_ALLOC;
            bit_next  = '0;
            case (kind_reg)
                KIND_ALLOC_SLICE:
                begin
                    new_fill = '0;
                end
                KIND_ALLOC_L2, KIND_ALLOC_PAGE:
                begin
                    full_mask = (kind_reg == KIND_ALLOC_L2) ? L2_FULL : PG_FULL;
                    base_fill = fresh_reg ? '0 : r_fill;
                    fc        = first_clear(base_fill, full_mask);
                    bit_next  = fc[2:0];
                    new_fill  = base_fill | (FILL_W'(1) << fc[2:0]);
                    push_next = ((new_fill & full_mask) != full_mask);
                    ptag_next = (kind_reg == KIND_ALLOC_L2) ? TAG_L2 : TAG_PAGE;
                    if (!fc[3])
                    begin
                        stat.upd_stop   = 1'b1;
                        res_status_next = RES_OOM;
                    end
                end
                KIND_FREE_SLICE:
                begin
                    new_fill  = '0;
                    push_next = 1'b1;
                    ptag_next = TAG_UNUSED;
                end
                default:
                begin
                    new_fill  = r_fill & ~(FILL_W'(1) << sub_reg);
                    push_next = 1'b1;
                    if (new_fill == '0)
                    begin
                        ptag_next = TAG_UNUSED;
                    end
                    else
                    begin
                        ptag_next = (kind_reg == KIND_FREE_L2) ? TAG_L2 : TAG_PAGE;
                    end
                end
            endcase
            if ((kind_reg inside {KIND_FREE_SLICE, KIND_FREE_L2, KIND_FREE_PAGE}) && r_resv)
            begin
                stat.upd_stop   = 1'b1;
                res_status_next = RES_RESERVED;
            end
            fill_next = new_fill;
            // Unlink the slice from whatever list holds it.
            if (!stat.upd_stop && (r_tag != TAG_ALLOC))
            begin
                if (next_rdata != NIL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata[IW-1:0];
                    prev_wdata = prev_rdata;
                end
                if (prev_rdata != NIL)
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata[IW-1:0];
                    next_wdata = next_rdata;
                end
                else
                begin
                    case (r_tag)
                        TAG_UNUSED: uh_next  = next_rdata;
                        TAG_L2:     l2h_next = next_rdata;
                        TAG_PAGE:   pgh_next = next_rdata;
                        default:    ;
                    endcase
                end
            end
        end

        if (cmd.push1)
        begin
            stat.do_push = push_reg;
            info_we      = 1'b1;
            info_wdata   = {(push_reg ? ptag_reg : TAG_ALLOC), fill_reg, resv_reg};
            case (ptag_reg)
                TAG_UNUSED: h_sel = uh_reg;
                TAG_L2:     h_sel = l2h_reg;
                TAG_PAGE:   h_sel = pgh_reg;
                default:    h_sel = NIL;
            endcase
            if (push_reg)
            begin
                next_we    = 1'b1;
                next_wdata = h_sel;
                if (h_sel != NIL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = h_sel[IW-1:0];
                    prev_wdata = W'(s_reg);
                end
                case (ptag_reg)
                    TAG_UNUSED: uh_next  = W'(s_reg);
                    TAG_L2:     l2h_next = W'(s_reg);
                    TAG_PAGE:   pgh_next = W'(s_reg);
                    default:    ;
                endcase
            end
            case (kind_reg)
                KIND_ALLOC_SLICE: res_block_next = blk_reg;
                KIND_ALLOC_L2:    res_block_next = blk_reg + 32'(bit_reg) * L2_BYTES;
                KIND_ALLOC_PAGE:  res_block_next = blk_reg + 32'(bit_reg) * PG_BYTES;
                default:          res_block_next = '0;
            endcase
        end

        if (cmd.push2)
        begin
            prev_we = 1'b1;
        end

        // Init walk: one slice per cycle, pushing free slices in ascending order.
        if (cmd.walk)
        begin
            stat.walk_last = (idx_reg == LAST_IDX);
            info_we        = 1'b1;
            info_waddr     = idx_reg;
            if (managed && !win_hit)
            begin
                info_wdata = {TAG_UNUSED, {FILL_W{1'b0}}, 1'b0};
                next_we    = 1'b1;
                next_waddr = idx_reg;
                next_wdata = uh_reg;
                if (uh_reg != NIL)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = uh_reg[IW-1:0];
                    prev_wdata = W'(idx_reg);
                end
                uh_next = W'(idx_reg);
            end
            else
            begin
                info_wdata = {TAG_ALLOC, {FILL_W{1'b0}}, managed && win_hit};
            end
            idx_next = idx_reg + IW'(1);
            acc_next = acc_reg + SLICE_BYTES;
        end

        if (cmd.fin && (uh_reg != NIL))
        begin
            prev_we    = 1'b1;
            prev_waddr = uh_reg[IW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uh_reg     <= NIL;
            l2h_reg    <= NIL;
            pgh_reg    <= NIL;
            mbase_reg  <= '0;
            mcount_reg <= '0;
        end
        else
        begin
            uh_reg     <= uh_next;
            l2h_reg    <= l2h_next;
            pgh_reg    <= pgh_next;
            mbase_reg  <= mbase_next;
            mcount_reg <= mcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        s_reg          <= s_next;
        fresh_reg      <= fresh_next;
        in_reg         <= in_next;
        blk_reg        <= blk_next;
        sub_reg        <= sub_next;
        fill_reg       <= fill_next;
        ptag_reg       <= ptag_next;
        push_reg       <= push_next;
        resv_reg       <= resv_next;
        bit_reg        <= bit_next;
        idx_reg        <= idx_next;
        acc_reg        <= acc_next;
        res_block_reg  <= res_block_next;
        res_status_reg <= res_status_next;
    end

    spa_ram #(.WIDTH(INFO_W), .DEPTH(SLICE_COUNT)) u_info_ram (
        .clk   (clk),
        .we    (info_we),
        .waddr (info_waddr),
        .wdata (info_wdata),
        .raddr (s_reg),
        .rdata (info_rdata)
    );

    spa_ram #(.WIDTH(W), .DEPTH(SLICE_COUNT)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (s_reg),
        .rdata (next_rdata)
    );

    spa_ram #(.WIDTH(W), .DEPTH(SLICE_COUNT)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (s_reg),
        .rdata (prev_rdata)
    );

    assign block_address = res_block_reg;
    assign status        = res_status_reg;

endmodule
`default_nettype wire

>>> rtl/slice_page_allocator_unit.sv
// Top level of the slice page allocator: register port, controller, datapath.
// Allocate or free: the done strobe follows the states DECIDE, READ, UPD, PUSH1 and PUSH2
// when pushed onto a list, DECIDE to PUSH1 when not, DECIDE to UPD when refused after the
// slice read, and DECIDE alone when refused at once. Busy drops with the strobe, so the
// next word may be accepted in the strobe cycle. Init walks one slice per cycle.
// Reset: list heads null, no slice managed; the slice memories are not cleared, so issue
// an init word before any allocation. Results cannot be stalled.
`default_nettype none
module slice_page_allocator_unit
    import spa_pkg::*;
#(
    parameter int SLICE_COUNT     = 1024,
    parameter int SLICE_SHIFT     = 14,
    parameter int L2_PER_SLICE    = 8,
    parameter int PAGES_PER_SLICE = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] address,
    output logic             done,
    output logic      [31:0] block_address,
    output logic      [1:0]  status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [31:0] region_base_reg;
    logic [10:0] slices_in_use_reg;
    logic [31:0] reserved_base_reg;
    logic [31:0] reserved_limit_reg;
    logic        cfg_write;
    spa_cmd_t    cmd;
    spa_stat_t   stat;

    // Registers sit at word-aligned byte addresses; writes land in the access phase.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg    <= '0;
            slices_in_use_reg  <= 11'd1024;
            reserved_base_reg  <= '0;
            reserved_limit_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_REGION_BASE:    region_base_reg    <= pwdata;
                REG_SLICES_IN_USE:  slices_in_use_reg  <= pwdata[10:0];
                REG_RESERVED_BASE:  reserved_base_reg  <= pwdata;
                REG_RESERVED_LIMIT: reserved_limit_reg <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_REGION_BASE:    prdata = region_base_reg;
            REG_SLICES_IN_USE:  prdata = 32'(slices_in_use_reg);
            REG_RESERVED_BASE:  prdata = reserved_base_reg;
            REG_RESERVED_LIMIT: prdata = reserved_limit_reg;
            default:            prdata = '0;
        endcase
    end

    // Controller steps the item; datapath holds lists, memories and the result word.
    spa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .stat  (stat)
    );

    spa_datapath #(
        .SLICE_COUNT     (SLICE_COUNT),
        .SLICE_SHIFT     (SLICE_SHIFT),
        .L2_PER_SLICE    (L2_PER_SLICE),
        .PAGES_PER_SLICE (PAGES_PER_SLICE)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .kind           (kind),
        .address        (address),
        .region_base    (region_base_reg),
        .slices_in_use  (slices_in_use_reg),
        .reserved_base  (reserved_base_reg),
        .reserved_limit (reserved_limit_reg),
        .block_address  (block_address),
        .status         (status)
    );

endmodule
`default_nettype wire

>>> verif/slice_page_allocator_unit_tb.sv
// Self-checking testbench for the slice page allocator: directed and random command words.
`default_nettype none
module slice_page_allocator_unit_tb;
    import spa_pkg::*;

    localparam int NSLICE = 1024;
    localparam int SHIFT  = 14;
    localparam int NL2    = 8;
    localparam int NPAGE  = 2;
    localparam int NIL    = NSLICE;

    localparam string PASS_TEXT = "DONE: 0 errors";

    typedef struct {
        logic [31:0] block;
        logic [1:0]  status;
    } answer_t;

    typedef struct {
        logic [31:0] addr;
        logic [2:0]  kind;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  kind = KIND_INIT;
    logic [31:0] address = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         busy;
    wire         done;
    wire  [31:0] block_address;
    wire  [1:0]  status;
    wire  [31:0] prdata;
    wire         pready;

    slice_page_allocator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .address(address), .done(done), .block_address(block_address), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // Shadow of the register file; only init latches it into the allocator.
    logic [31:0] cfg_base = '0;
    logic [10:0] cfg_count = 11'd1024;
    logic [31:0] cfg_rbase = '0;
    logic [31:0] cfg_rlimit = '0;

    // Allocator bookkeeping, mirrored slice by slice.
    logic [1:0]  slice_tag [NSLICE];
    logic [7:0]  slice_fill [NSLICE];
    logic        slice_rsv [NSLICE];
    int          link_nxt [NSLICE];
    int          link_prv [NSLICE];
    int          list_head [4];
    logic [31:0] live_base;
    logic [31:0] live_count;

    answer_t     pending_q[$];
    grant_t      granted_q[$];
    int          err_count = 0;
    int          burst_left = 0;

    initial begin
        for (int i = 0; i < NSLICE; i++) begin
            slice_tag[i] = TAG_UNUSED;
            slice_fill[i] = '0;
            slice_rsv[i] = 1'b0;
            link_nxt[i] = 0;
            link_prv[i] = 0;
        end
        for (int i = 0; i < 4; i++) list_head[i] = NIL;
        live_base = '0;
        live_count = '0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic logic [31:0] slice_start(int s);
        return live_base + (32'(s) << SHIFT);
    endfunction

    // Put a slice at the head of the list of its new tag; allocated slices sit on no list.
    function automatic void list_push(logic [1:0] t, int s);
        slice_tag[s] = t;
        link_prv[s] = NIL;
        link_nxt[s] = NIL;
        if (t == TAG_ALLOC) return;
        link_nxt[s] = list_head[t];
        if (list_head[t] < NIL) link_prv[list_head[t]] = s;
        list_head[t] = s;
    endfunction

    // Take a slice off whatever list holds it and mark it allocated.
    function automatic void list_drop(int s);
        logic [1:0] t;
        int n;
        int p;
        t = slice_tag[s];
        n = link_nxt[s];
        p = link_prv[s];
        if (t != TAG_ALLOC) begin
            if (n < NIL) link_prv[n] = p;
            if (p < NIL) link_nxt[p] = n;
            else list_head[t] = n;
        end
        link_nxt[s] = NIL;
        link_prv[s] = NIL;
        slice_tag[s] = TAG_ALLOC;
    endfunction

    function automatic void rebuild_lists();
        int cnt;
        logic [31:0] a;
        cnt = (cfg_count < NSLICE) ? int'(cfg_count) : NSLICE;
        for (int i = 0; i < 4; i++) list_head[i] = NIL;
        live_base = cfg_base;
        live_count = 32'(cnt);
        for (int s = 0; s < NSLICE; s++) begin
            slice_tag[s] = TAG_ALLOC;
            slice_fill[s] = '0;
            slice_rsv[s] = 1'b0;
            link_nxt[s] = NIL;
            link_prv[s] = NIL;
        end
        for (int s = 0; s < cnt; s++) begin
            a = slice_start(s);
            if (cfg_rlimit > cfg_rbase && a >= cfg_rbase && a < cfg_rlimit)
                slice_rsv[s] = 1'b1;
            else
                list_push(TAG_UNUSED, s);
        end
    endfunction

    // Sub-block allocation: partial list head first, else a fresh slice.
    function automatic logic [1:0] carve_sub(logic [1:0] t, int parts, output logic [31:0] a);
        logic [7:0] full;
        int s;
        int b;
        a = '0;
        full = 8'((1 << parts) - 1);
        s = list_head[t];
        if (s >= NIL) begin
            s = list_head[TAG_UNUSED];
            if (s >= NIL) return RES_OOM;
            list_drop(s);
            slice_fill[s] = '0;
        end
        for (b = 0; b < parts; b++)
            if (!slice_fill[s][b]) break;
        if (b >= parts) return RES_OOM;
        slice_fill[s][b] = 1'b1;
        if ((slice_fill[s] & full) == full) list_drop(s);
        else if (slice_tag[s] != t) list_push(t, s);
        a = slice_start(s) + 32'(b * ((1 << SHIFT) / parts));
        return RES_OK;
    endfunction

    function automatic logic [1:0] release_block(logic [2:0] k, logic [31:0] a);
        logic [31:0] off;
        logic [31:0] sl;
        int s;
        int parts;
        int sub;
        off = a - live_base;
        sl = off >> SHIFT;
        if (sl >= live_count) return RES_RANGE;
        s = int'(sl);
        if (slice_rsv[s]) return RES_RESERVED;
        list_drop(s);
        if (k == KIND_FREE_SLICE) begin
            slice_fill[s] = '0;
            list_push(TAG_UNUSED, s);
            return RES_OK;
        end
        parts = (k == KIND_FREE_L2) ? NL2 : NPAGE;
        sub = int'(off[SHIFT-1:0]) / ((1 << SHIFT) / parts);
        slice_fill[s][sub & 7] = 1'b0;
        if (slice_fill[s] == 0) list_push(TAG_UNUSED, s);
        else list_push((k == KIND_FREE_L2) ? TAG_L2 : TAG_PAGE, s);
        return RES_OK;
    endfunction

    function automatic answer_t predict_answer(logic [2:0] k, logic [31:0] a);
        answer_t r;
        int s;
        r.block = '0;
        r.status = RES_OK;
        case (k)
            KIND_INIT: rebuild_lists();
            KIND_ALLOC_SLICE: begin
                s = list_head[TAG_UNUSED];
                if (s >= NIL) r.status = RES_OOM;
                else begin
                    list_drop(s);
                    slice_fill[s] = '0;
                    r.block = slice_start(s);
                end
            end
            KIND_ALLOC_L2:   r.status = carve_sub(TAG_L2, NL2, r.block);
            KIND_ALLOC_PAGE: r.status = carve_sub(TAG_PAGE, NPAGE, r.block);
            KIND_FREE_SLICE, KIND_FREE_L2, KIND_FREE_PAGE: r.status = release_block(k, a);
            default: ;
        endcase
        if (r.status != RES_OK) r.block = '0;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Result checking: every done strobe retires the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        answer_t want;
        if (rst_n && done) begin
            if (pending_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected word: block %h status %0d", block_address, status);
            end else begin
                want = pending_q.pop_front();
                if (block_address !== want.block || status !== want.status) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: block exp %h got %h, status exp %0d got %0d",
                                 want.block, block_address, want.status, status);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers; each is entered just after a rising edge
    // ---------------------------------------------------------------

    // Drive one command word, hold it until accepted, then log the prediction.
    task automatic send_word(logic [2:0] k, logic [31:0] a);
        answer_t r;
        int gap;
        start <= 1'b1;
        kind <= k;
        address <= a;
        do @(posedge clk); while (busy !== 1'b0);
        r = predict_answer(k, a);
        pending_q.push_back(r);
        if (r.status == RES_OK && k >= KIND_ALLOC_SLICE && k <= KIND_ALLOC_PAGE)
            granted_q.push_back('{addr: r.block, kind: k});
        if (k == KIND_INIT) granted_q.delete();
        // Burst bookkeeping: drop start at burst end and idle for a random gap.
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            start <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Hold off the sender until every expected word has come back.
    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_REGION_BASE:    cfg_base = v;
            REG_SLICES_IN_USE:  cfg_count = v[10:0];
            REG_RESERVED_BASE:  cfg_rbase = v;
            default:            cfg_rlimit = v;
        endcase
        @(posedge clk);
    endtask

    task automatic configure(logic [31:0] b, logic [31:0] n, logic [31:0] rb, logic [31:0] rl);
        drain();
        reg_write(REG_REGION_BASE, b);
        reg_write(REG_SLICES_IN_USE, n);
        reg_write(REG_RESERVED_BASE, rb);
        reg_write(REG_RESERVED_LIMIT, rl);
    endtask

    // Any address within the managed span (slice 0 when none is managed), aligned or not.
    function automatic logic [31:0] region_addr();
        logic [31:0] span;
        span = (live_count == 0) ? 32'd1 : live_count;
        return live_base + ($urandom_range(0, int'(span) - 1) << SHIFT) + $urandom_range(0, 16383);
    endfunction

    // One random word: mostly alloc/free pairs over live grants, some noise.
    task automatic random_word();
        int r;
        int idx;
        grant_t g;
        logic [2:0] fk;
        logic [31:0] a;
        r = $urandom_range(0, 199);
        if (r < 90) begin
            send_word(3'($urandom_range(KIND_ALLOC_SLICE, KIND_ALLOC_PAGE)), $urandom);
        end else if (r < 170 && granted_q.size() != 0) begin
            idx = $urandom_range(0, granted_q.size() - 1);
            g = granted_q[idx];
            granted_q.delete(idx);
            // Free the grant with its own kind most of the time, else a random free kind.
            fk = (g.kind == KIND_ALLOC_SLICE) ? KIND_FREE_SLICE :
                 (g.kind == KIND_ALLOC_L2) ? KIND_FREE_L2 : KIND_FREE_PAGE;
            if ($urandom_range(0, 9) == 0) fk = 3'($urandom_range(KIND_FREE_SLICE, KIND_FREE_PAGE));
            a = g.addr + ((fk == KIND_FREE_SLICE) ? $urandom_range(0, 16383) :
                          (fk == KIND_FREE_L2) ? $urandom_range(0, 2047) : $urandom_range(0, 8191));
            send_word(fk, a);
        end else if (r < 186) begin
            a = ($urandom_range(0, 2) == 0) ? $urandom : region_addr();
            send_word(3'($urandom_range(KIND_FREE_SLICE, KIND_FREE_PAGE)), a);
        end else if (r < 197) begin
            send_word(3'd7, $urandom);
        end else begin
            send_word(KIND_INIT, $urandom);
        end
    endtask

    task automatic random_phase(logic [31:0] b, logic [31:0] n, logic [31:0] rb,
                                logic [31:0] rl, int cnt);
        configure(b, n, rb, rl);
        send_word(KIND_INIT, '0);
        repeat (cnt) random_word();
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Before any init: allocations run dry, frees fall outside the region.
    task automatic test_before_init();
        send_word(KIND_ALLOC_SLICE, '0);
        send_word(KIND_ALLOC_L2, '0);
        send_word(KIND_ALLOC_PAGE, 32'hffff_ffff);
        send_word(KIND_FREE_SLICE, '0);
        send_word(KIND_FREE_L2, 32'h0000_4000);
        send_word(KIND_FREE_PAGE, 32'hffff_ffff);
        send_word(3'd7, 32'h5555_aaaa);
    endtask

    // Small region with a reserved slice: every kind, mismatched frees, exhaustion.
    task automatic test_directed();
        configure(32'h8000_0000, 32'd4, 32'h8000_4000, 32'h8000_8000);
        send_word(KIND_INIT, '0);
        send_word(KIND_ALLOC_L2, '0);
        send_word(KIND_ALLOC_L2, '0);
        send_word(KIND_ALLOC_PAGE, '0);
        send_word(KIND_ALLOC_SLICE, '0);
        send_word(KIND_ALLOC_SLICE, '0);
        send_word(KIND_FREE_L2, 32'h8000_c000);
        send_word(KIND_FREE_PAGE, 32'h8000_87ff);
        send_word(KIND_FREE_PAGE, 32'h8000_a000);
        send_word(KIND_FREE_SLICE, 32'h8000_4010);
        send_word(KIND_FREE_L2, 32'h8001_0000);
        send_word(KIND_FREE_SLICE, 32'h7fff_ffff);
        send_word(KIND_FREE_SLICE, 32'h8000_0000);
        send_word(KIND_ALLOC_PAGE, '0);
        send_word(KIND_ALLOC_PAGE, '0);
        send_word(KIND_ALLOC_PAGE, '0);
        send_word(KIND_ALLOC_PAGE, '0);
        send_word(3'd7, 32'hffff_ffff);
    endtask

    // Register extremes: no slices, oversized count, wrapped base, window over everything.
    task automatic test_register_extremes();
        random_phase(32'h0, 32'd0, 32'h0, 32'h0, 20);
        random_phase(32'hffff_c000, 32'd2047, 32'hffff_ffff, 32'h0, 120);
        random_phase(32'h0, 32'd1024, 32'h0, 32'hffff_ffff, 20);
        random_phase(32'h1234_5678, 32'd1, 32'h0, 32'h0, 40);
    endtask

    task automatic test_random_traffic();
        random_phase(32'h4000_0000, 32'd8, 32'h4000_8000, 32'h4000_c000, 450);
        random_phase(32'hfff0_2000, 32'd64, 32'h0000_0000, 32'h0002_0000, 450);
        random_phase(32'h0000_0123, 32'd3, 32'hffff_ffff, 32'h0000_0001, 250);
        random_phase(32'h0, 32'd1024, 32'h0000_4000, 32'h0040_0000, 250);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_init();
        test_directed();
        test_register_extremes();
        test_random_traffic();
        drain();
        if (pending_q.size() != 0) err_count++;
        if (err_count == 0)
            $display(PASS_TEXT);
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run (inits dominate).
    initial begin
        #(20 * 3_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire
